### sv/igt_pkg.sv
// Shared types, constants and codes for the image geometric transform block.
// Used by every module in this folder but igt_ram; depends on nothing else.
package igt_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int XW         = $clog2(MaxWidth);
  localparam int YW         = $clog2(MaxHeight);
  localparam int FrameDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = XW + YW;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    MODE_IDENTITY = 3'd0,
    MODE_FLIP_H   = 3'd1,
    MODE_FLIP_V   = 3'd2,
    MODE_ROT_L    = 3'd3,
    MODE_ROT_R    = 3'd4,
    MODE_CROP     = 3'd5,
    MODE_SCALE    = 3'd6,
    MODE_UNUSED   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_IN_W     = 3'd1,
    REG_IN_H     = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4,
    REG_OUT_W    = 3'd5,
    REG_OUT_H    = 3'd6,
    REG_MASK     = 3'd7
  } reg_idx_t;

  // Kind of work the back end must do for one queued item.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SCALE = 2'd2,
    OP_ERROR = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  sx;       // source column, or output x for a scale read
    logic [9:0]  sy;       // source row, or output y for a scale read
    logic [23:0] rgb;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [8:0] in_width;
    logic [8:0] in_height;
    logic [8:0] origin_x;
    logic [8:0] origin_y;
    logic [9:0] out_width;
    logic [9:0] out_height;
    logic [2:0] channel_mask;
  } cfg_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_DIV_X,
    BE_DIV_Y,
    BE_CHECK,
    BE_RD,
    BE_OUT
  } be_state_t;

endpackage

### sv/igt_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module igt_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/igt_front.sv
// Front end: accepts items, checks them and maps fixed transforms to source
// coordinates. Depends on igt_pkg.
module igt_front (
  input  igt_pkg::cfg_t    cfg,
  input  logic             valid,
  output logic             stall,
  input  logic             req_type,
  input  logic [9:0]       pixel_x,
  input  logic [9:0]       pixel_y,
  input  logic [7:0]       red_in,
  input  logic [7:0]       green_in,
  input  logic [7:0]       blue_in,
  output logic             q_push,
  output igt_pkg::cmd_t    q_data,
  input  logic             q_full
);

  logic        size_ok;
  logic [10:0] w;
  logic [10:0] h;
  logic [10:0] x;
  logic [10:0] y;
  logic        ok;
  logic [10:0] sx;
  logic [10:0] sy;

  assign stall  = q_full;
  assign q_push = valid && !q_full;

  always_comb begin
    w  = {2'b0, cfg.in_width};
    h  = {2'b0, cfg.in_height};
    x  = {1'b0, pixel_x};
    y  = {1'b0, pixel_y};
    size_ok = (w != 11'd0) && (h != 11'd0) && (w <= 11'(igt_pkg::MaxWidth))
              && (h <= 11'(igt_pkg::MaxHeight));
    ok = 1'b0;
    sx = x;
    sy = y;
    case (igt_pkg::mode_t'(cfg.mode))
      igt_pkg::MODE_IDENTITY: ok = (x < w) && (y < h);
      igt_pkg::MODE_FLIP_H: begin
        ok = (x < w) && (y < h);
        sx = w - 11'd1 - x;
      end
      igt_pkg::MODE_FLIP_V: begin
        ok = (x < w) && (y < h);
        sy = h - 11'd1 - y;
      end
      igt_pkg::MODE_ROT_L: begin
        ok = (x < h) && (y < w);
        sx = y;
        sy = h - 11'd1 - x;
      end
      igt_pkg::MODE_ROT_R: begin
        ok = (x < h) && (y < w);
        sx = w - 11'd1 - y;
        sy = x;
      end
      igt_pkg::MODE_CROP: begin
        ok = ({2'b0, cfg.origin_x} + {1'b0, cfg.out_width} <= w)
             && ({2'b0, cfg.origin_y} + {1'b0, cfg.out_height} <= h)
             && (x < {1'b0, cfg.out_width}) && (y < {1'b0, cfg.out_height});
        sx = {2'b0, cfg.origin_x} + x;
        sy = h - {2'b0, cfg.origin_y} - {1'b0, cfg.out_height} + y;
      end
      igt_pkg::MODE_SCALE:
        ok = (cfg.out_width != 10'd0) && (cfg.out_height != 10'd0)
             && (x < {1'b0, cfg.out_width}) && (y < {1'b0, cfg.out_height});
      default: ok = 1'b0;
    endcase

    q_data.rgb = {blue_in, green_in, red_in};
    q_data.sx  = sx[9:0];
    q_data.sy  = sy[9:0];
    if (!req_type) begin
      q_data.op = (size_ok && x < w && y < h) ? igt_pkg::OP_WRITE : igt_pkg::OP_ERROR;
      q_data.sx = pixel_x;
      q_data.sy = pixel_y;
      // A write outside the source is dropped; an all-ones column marks it
      // so that the back end discards it without a result.
      q_data.rgb = {blue_in, green_in, red_in};
      if (!(size_ok && x < w && y < h)) begin
        q_data.op = igt_pkg::OP_WRITE;
        q_data.sx = 10'h3FF;
      end
    end else if (cfg.channel_mask == 3'd0 || !size_ok || !ok) begin
      q_data.op = igt_pkg::OP_ERROR;
    end else if (igt_pkg::mode_t'(cfg.mode) == igt_pkg::MODE_SCALE) begin
      q_data.op = igt_pkg::OP_SCALE;
      q_data.sx = pixel_x;
      q_data.sy = pixel_y;
    end else begin
      q_data.op = igt_pkg::OP_READ;
    end
  end

endmodule

### sv/igt_queue.sv
// Short FIFO of commands between the front and back ends.
// Depends on igt_pkg.
module igt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  igt_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output igt_pkg::cmd_t rdata,
  output logic          empty
);

  igt_pkg::cmd_t                 slots [igt_pkg::QueueDepth];
  logic [igt_pkg::QPtrW-1:0]     wp;
  logic [igt_pkg::QPtrW-1:0]     rp;
  logic [igt_pkg::QPtrW:0]       count;

  assign full  = count == (igt_pkg::QPtrW+1)'(igt_pkg::QueueDepth);
  assign empty = count == '0;
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wdata;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + {{igt_pkg::QPtrW{1'b0}}, push} - {{igt_pkg::QPtrW{1'b0}}, pop};
    end
  end

endmodule

### sv/igt_back.sv
// Back end: writes the frame store, runs the shared divider for scale reads,
// reads the frame and holds the result. Depends on igt_pkg and igt_ram.
module igt_back (
  input  logic          clk,
  input  logic          rst,
  input  igt_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  igt_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          valid,
  input  logic          stall,
  output logic [7:0]    red_out,
  output logic [7:0]    green_out,
  output logic [7:0]    blue_out,
  output logic          error
);

  igt_pkg::be_state_t state, state_next;
  logic [19:0] rem;
  logic [18:0] quo;
  logic [4:0]  step;
  logic [9:0]  sx;
  logic [9:0]  sy;
  logic        err;
  logic [10:0] divisor;
  logic [20:0] trial;
  logic        we;
  logic [igt_pkg::AddrW-1:0] addr;
  logic [23:0] rdata;
  logic        in_src;

  assign in_src = (sx < {1'b0, cfg.in_width}) && (sy < {1'b0, cfg.in_height});
  assign addr = (state == igt_pkg::BE_IDLE)
                ? {q_data.sy[igt_pkg::YW-1:0], q_data.sx[igt_pkg::XW-1:0]}
                : {sy[igt_pkg::YW-1:0], sx[igt_pkg::XW-1:0]};
  assign we = (state == igt_pkg::BE_IDLE) && !q_empty && q_data.op == igt_pkg::OP_WRITE
              && q_data.sx != 10'h3FF;

  igt_ram #(.Width(24), .Depth(igt_pkg::FrameDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(q_data.rgb), .rdata(rdata)
  );

  assign divisor = (state == igt_pkg::BE_DIV_X) ? {1'b0, cfg.out_width}
                                                : {1'b0, cfg.out_height};
  // One quotient bit per cycle; restoring division of a 19-bit product.
  assign trial = {rem, quo[18]} - {10'b0, divisor};

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      igt_pkg::BE_IDLE:
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_data.op)
            igt_pkg::OP_WRITE: state_next = igt_pkg::BE_IDLE;
            igt_pkg::OP_READ:  state_next = igt_pkg::BE_CHECK;
            igt_pkg::OP_SCALE: state_next = igt_pkg::BE_DIV_X;
            default:           state_next = igt_pkg::BE_OUT;
          endcase
        end
      igt_pkg::BE_DIV_X: if (step == 5'd18) state_next = igt_pkg::BE_DIV_Y;
      igt_pkg::BE_DIV_Y: if (step == 5'd18) state_next = igt_pkg::BE_CHECK;
      igt_pkg::BE_CHECK: state_next = in_src ? igt_pkg::BE_RD : igt_pkg::BE_OUT;
      igt_pkg::BE_RD:    state_next = igt_pkg::BE_OUT;
      igt_pkg::BE_OUT:   if (!stall) state_next = igt_pkg::BE_IDLE;
      default:           state_next = igt_pkg::BE_IDLE;
    endcase
  end

  assign valid = state == igt_pkg::BE_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= igt_pkg::BE_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      igt_pkg::BE_IDLE: begin
        sx   <= q_data.sx;
        sy   <= q_data.sy;
        err  <= q_data.op == igt_pkg::OP_ERROR;
        step <= '0;
        rem  <= '0;
        quo  <= 19'({q_data.sx} * {1'b0, cfg.in_width});
      end
      igt_pkg::BE_DIV_X, igt_pkg::BE_DIV_Y: begin
        if (!trial[20]) begin
          rem <= trial[19:0];
          quo <= {quo[17:0], 1'b1};
        end else begin
          rem <= {rem[18:0], quo[18]};
          quo <= {quo[17:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'd18) begin
          step <= '0;
          rem  <= '0;
          if (state == igt_pkg::BE_DIV_X) begin
            sx  <= {quo[8:0], !trial[20]};
            quo <= 19'(sy * {1'b0, cfg.in_height});
          end else begin
            sy <= {quo[8:0], !trial[20]};
          end
        end
      end
      igt_pkg::BE_CHECK: if (!in_src) err <= 1'b1;
      igt_pkg::BE_RD: begin
        red_out   <= cfg.channel_mask[0] ? rdata[7:0]   : 8'd0;
        green_out <= cfg.channel_mask[1] ? rdata[15:8]  : 8'd0;
        blue_out  <= cfg.channel_mask[2] ? rdata[23:16] : 8'd0;
      end
      default: ;
    endcase
    if (state_next == igt_pkg::BE_OUT && state != igt_pkg::BE_RD
        && state != igt_pkg::BE_OUT) begin
      red_out   <= 8'd0;
      green_out <= 8'd0;
      blue_out  <= 8'd0;
    end
  end

  assign error = err;

endmodule

### sv/image_geometric_transform.sv
// Top level of the image geometric transform frame store.
// Depends on igt_pkg, igt_front, igt_queue, igt_back and igt_ram.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------
//   in       | in        | in_valid / in_stall       | req_type pixel_x pixel_y rgb in
//   out      | out       | out_valid / out_stall     | red/green/blue_out error
//   config   | in        | APB psel/penable/pwrite   | paddr pwdata prdata
//
// A write is done while the back end is idle. A fixed-transform read passes
// the check, read (pixel inside the source only) and output states; a scale
// read first runs the shared restoring divider, 19 steps for each axis. Error
// reads go straight to output. A four-entry queue lets the front take items
// while the back is busy or out_stall holds a result. Reset (synchronous)
// clears control state only; the frame store holds whatever was last written.
module image_geometric_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  igt_pkg::cfg_t cfg;
  igt_pkg::cmd_t push_data;
  igt_pkg::cmd_t pop_data;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= igt_pkg::MODE_IDENTITY;
      cfg.in_width     <= 9'd256;
      cfg.in_height    <= 9'd256;
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.out_width    <= 10'd256;
      cfg.out_height   <= 10'd256;
      cfg.channel_mask <= 3'd7;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (igt_pkg::reg_idx_t'(reg_idx))
        igt_pkg::REG_MODE:     cfg.mode         <= pwdata[2:0];
        igt_pkg::REG_IN_W:     cfg.in_width     <= pwdata[8:0];
        igt_pkg::REG_IN_H:     cfg.in_height    <= pwdata[8:0];
        igt_pkg::REG_ORIGIN_X: cfg.origin_x     <= pwdata[8:0];
        igt_pkg::REG_ORIGIN_Y: cfg.origin_y     <= pwdata[8:0];
        igt_pkg::REG_OUT_W:    cfg.out_width    <= pwdata[9:0];
        igt_pkg::REG_OUT_H:    cfg.out_height   <= pwdata[9:0];
        igt_pkg::REG_MASK:     cfg.channel_mask <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (igt_pkg::reg_idx_t'(reg_idx))
      igt_pkg::REG_MODE:     prdata = {29'd0, cfg.mode};
      igt_pkg::REG_IN_W:     prdata = {23'd0, cfg.in_width};
      igt_pkg::REG_IN_H:     prdata = {23'd0, cfg.in_height};
      igt_pkg::REG_ORIGIN_X: prdata = {23'd0, cfg.origin_x};
      igt_pkg::REG_ORIGIN_Y: prdata = {23'd0, cfg.origin_y};
      igt_pkg::REG_OUT_W:    prdata = {22'd0, cfg.out_width};
      igt_pkg::REG_OUT_H:    prdata = {22'd0, cfg.out_height};
      igt_pkg::REG_MASK:     prdata = {29'd0, cfg.channel_mask};
      default:               prdata = '0;
    endcase
  end

  igt_front u_front (
    .cfg(cfg), .valid(in_valid), .stall(in_stall),
    .req_type(req_type), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .q_push(push), .q_data(push_data), .q_full(full)
  );

  igt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(push_data), .full(full),
    .pop(pop), .rdata(pop_data), .empty(empty)
  );

  igt_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(empty), .q_data(pop_data),
    .q_pop(pop), .valid(out_valid), .stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .error(error)
  );

endmodule

### sim/tb_image_geometric_transform.sv
// Self-checking testbench for the image geometric transform frame store.
// Depends on igt_pkg and image_geometric_transform; it drives items, predicts every
// result from its own frame copy and compares them as they leave the block.
module tb_image_geometric_transform;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietCycles = 80;
  localparam int StallLimit  = 5000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       err;
  } colour_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [9:0]  pixel_x = '0;
  logic [9:0]  pixel_y = '0;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  image_geometric_transform i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the configuration and of the frame store.
  logic [2:0]  cur_mode = igt_pkg::MODE_IDENTITY;
  logic [8:0]  cur_in_w = 9'd256;
  logic [8:0]  cur_in_h = 9'd256;
  logic [8:0]  cur_org_x = '0;
  logic [8:0]  cur_org_y = '0;
  logic [9:0]  cur_out_w = 10'd256;
  logic [9:0]  cur_out_h = 10'd256;
  logic [2:0]  cur_mask = 3'd7;
  logic [23:0] frame_copy [igt_pkg::FrameDepth];
  bit          frame_written [igt_pkg::FrameDepth];

  colour_t expected_pixels[$];
  int unsigned fail_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic bit size_valid();
    return cur_in_w != 0 && cur_in_h != 0 && cur_in_w <= igt_pkg::MaxWidth
           && cur_in_h <= igt_pkg::MaxHeight;
  endfunction

  // Output coordinates back to source coordinates; 0 means an error read.
  function automatic bit source_of(int x, int y, output int sx, output int sy);
    int w, h;
    w = cur_in_w;
    h = cur_in_h;
    sx = 0;
    sy = 0;
    if (cur_mask == 0 || !size_valid()) return 0;
    case (cur_mode)
      igt_pkg::MODE_IDENTITY, igt_pkg::MODE_FLIP_H, igt_pkg::MODE_FLIP_V: begin
        if (x >= w || y >= h) return 0;
        sx = (cur_mode == igt_pkg::MODE_FLIP_H) ? w - 1 - x : x;
        sy = (cur_mode == igt_pkg::MODE_FLIP_V) ? h - 1 - y : y;
      end
      igt_pkg::MODE_ROT_L: begin
        if (x >= h || y >= w) return 0;
        sx = y;
        sy = h - 1 - x;
      end
      igt_pkg::MODE_ROT_R: begin
        if (x >= h || y >= w) return 0;
        sx = w - 1 - y;
        sy = x;
      end
      igt_pkg::MODE_CROP: begin
        if (cur_org_x + cur_out_w > w || cur_org_y + cur_out_h > h) return 0;
        if (x >= cur_out_w || y >= cur_out_h) return 0;
        sx = cur_org_x + x;
        sy = h - cur_org_y - cur_out_h + y;
      end
      igt_pkg::MODE_SCALE: begin
        if (cur_out_w == 0 || cur_out_h == 0) return 0;
        if (x >= cur_out_w || y >= cur_out_h) return 0;
        sx = (x * w) / cur_out_w;
        sy = (y * h) / cur_out_h;
      end
      default: return 0;
    endcase
    return sx < w && sy < h;
  endfunction

  function automatic colour_t predict_read(int x, int y);
    colour_t res;
    int sx, sy;
    logic [23:0] pix;
    res = '{8'd0, 8'd0, 8'd0, 1'b1};
    if (source_of(x, y, sx, sy)) begin
      pix = frame_copy[sy * igt_pkg::MaxWidth + sx];
      res.red   = cur_mask[0] ? pix[7:0]   : 8'd0;
      res.green = cur_mask[1] ? pix[15:8]  : 8'd0;
      res.blue  = cur_mask[2] ? pix[23:16] : 8'd0;
      res.err   = 1'b0;
    end
    return res;
  endfunction

  // Output size of the current transform, used to aim reads.
  task automatic output_dims(output int ow, output int oh);
    case (cur_mode)
      igt_pkg::MODE_ROT_L, igt_pkg::MODE_ROT_R: begin ow = cur_in_h; oh = cur_in_w; end
      igt_pkg::MODE_CROP, igt_pkg::MODE_SCALE:  begin ow = cur_out_w; oh = cur_out_h; end
      default:                                  begin ow = cur_in_w; oh = cur_in_h; end
    endcase
    if (ow > 1024) ow = 1024;
    if (oh > 1024) oh = 1024;
  endtask

  task automatic send_item(bit is_read, int x, int y, logic [23:0] rgb);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= is_read;
    pixel_x  <= x[9:0];
    pixel_y  <= y[9:0];
    red_in   <= rgb[7:0];
    green_in <= rgb[15:8];
    blue_in  <= rgb[23:16];
    do @(posedge clk); while (in_stall);
    if (is_read) begin
      expected_pixels.push_back(predict_read(x[9:0], y[9:0]));
    end else if (size_valid() && x[9:0] < cur_in_w && y[9:0] < cur_in_h) begin
      frame_copy[y[9:0] * igt_pkg::MaxWidth + x[9:0]] = rgb;
      frame_written[y[9:0] * igt_pkg::MaxWidth + x[9:0]] = 1'b1;
    end
  endtask

  // A read whose source pixel was never written is preceded by a write to it.
  task automatic read_pixel(int x, int y);
    int sx, sy;
    if (source_of(x, y, sx, sy) && !frame_written[sy * igt_pkg::MaxWidth + sx])
      send_item(1'b0, sx, sy, 24'($urandom()));
    send_item(1'b1, x, y, '0);
  endtask

  // Waits for every result, then for any write still in the back end.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic apb_write(igt_pkg::reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int m, int w, int h, int ox, int oy, int ow, int oh, int mask);
    settle();
    cur_mode  = 3'(m);
    cur_in_w  = 9'(w);
    cur_in_h  = 9'(h);
    cur_org_x = 9'(ox);
    cur_org_y = 9'(oy);
    cur_out_w = 10'(ow);
    cur_out_h = 10'(oh);
    cur_mask  = 3'(mask);
    apb_write(igt_pkg::REG_MODE, 32'(cur_mode));
    apb_write(igt_pkg::REG_IN_W, 32'(cur_in_w));
    apb_write(igt_pkg::REG_IN_H, 32'(cur_in_h));
    apb_write(igt_pkg::REG_ORIGIN_X, 32'(cur_org_x));
    apb_write(igt_pkg::REG_ORIGIN_Y, 32'(cur_org_y));
    apb_write(igt_pkg::REG_OUT_W, 32'(cur_out_w));
    apb_write(igt_pkg::REG_OUT_H, 32'(cur_out_h));
    apb_write(igt_pkg::REG_MASK, 32'(cur_mask));
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    fail_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    colour_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report("unexpected result item", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (red_out !== want.red)     report("red_out", red_out, want.red);
        if (green_out !== want.green) report("green_out", green_out, want.green);
        if (blue_out !== want.blue)   report("blue_out", blue_out, want.blue);
        if (error !== want.err)       report("error", error, want.err);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Watchdog on cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_default_frame();
    send_item(1'b0, 0, 0, 24'hFFFFFF);
    send_item(1'b0, 255, 255, 24'h000000);
    send_item(1'b0, 255, 0, 24'hA5C33C);
    send_item(1'b0, 256, 0, 24'h123456);
    send_item(1'b0, 1023, 1023, 24'hFFFFFF);
    read_pixel(0, 0);
    read_pixel(255, 255);
    read_pixel(255, 0);
    read_pixel(256, 0);
    read_pixel(1023, 1023);
  endtask

  // Two reads in each mode on a small image, then the error settings.
  task automatic test_each_mode();
    for (int m = igt_pkg::MODE_IDENTITY; m <= igt_pkg::MODE_UNUSED; m++) begin
      configure(m, 5, 3, 1, 1, 3, 2, 7);
      read_pixel(0, 0);
      read_pixel(1, 2);
    end
    configure(igt_pkg::MODE_CROP, 4, 4, 2, 0, 3, 4, 7);  // crop runs past the right edge
    read_pixel(0, 0);
    configure(igt_pkg::MODE_SCALE, 4, 4, 0, 0, 0, 1023, 5);  // empty scale output
    read_pixel(0, 0);
    configure(igt_pkg::MODE_IDENTITY, 4, 4, 256, 256, 1023, 1023, 0);  // empty mask
    read_pixel(1, 1);
    configure(igt_pkg::MODE_IDENTITY, 511, 0, 0, 0, 0, 0, 7);  // bad source size
    send_item(1'b0, 1, 0, 24'h010203);
    read_pixel(1, 0);
    configure(igt_pkg::MODE_CROP, 256, 256, 256, 256, 0, 0, 2);
    read_pixel(0, 0);
  endtask

  task automatic random_config();
    int w, h, m, ox, oy, ow, oh;
    m = ($urandom_range(15) == 0) ? igt_pkg::MODE_UNUSED
                                  : $urandom_range(igt_pkg::MODE_SCALE);
    w = $urandom_range(3) == 0 ? $urandom_range(1, 256) : $urandom_range(1, 24);
    h = $urandom_range(3) == 0 ? $urandom_range(1, 256) : $urandom_range(1, 24);
    if ($urandom_range(19) == 0) w = $urandom_range(1) ? 0 : $urandom_range(257, 511);
    if ($urandom_range(19) == 0) h = $urandom_range(1) ? 0 : $urandom_range(257, 511);
    if (m == igt_pkg::MODE_SCALE) begin
      ow = $urandom_range(1, 60);
      oh = $urandom_range(1, 60);
      if ($urandom_range(9) == 0) ow = $urandom_range(1) ? 0 : 1023;
    end else if (w <= 256 && h <= 256 && $urandom_range(7) != 0) begin
      ox = $urandom_range(w);
      oy = $urandom_range(h);
      ow = $urandom_range(w - ox);
      oh = $urandom_range(h - oy);
    end else begin
      ow = $urandom_range(1023);
      oh = $urandom_range(1023);
    end
    if (m != igt_pkg::MODE_CROP || w > 256 || h > 256) begin
      ox = $urandom_range(511);
      oy = $urandom_range(511);
    end
    configure(m, w, h, ox, oy, ow, oh, $urandom_range(7) == 0 ? 0 : $urandom_range(1, 7));
  endtask

  task automatic test_random_traffic(int items);
    int ow, oh, x, y;
    for (int i = 0; i < items; i++) begin
      if (i % 35 == 0) random_config();
      output_dims(ow, oh);
      if ($urandom_range(3) == 0) begin
        x = $urandom_range(7) == 0 ? $urandom_range(1023) : $urandom_range(cur_in_w);
        y = $urandom_range(7) == 0 ? $urandom_range(1023) : $urandom_range(cur_in_h);
        send_item(1'b0, x, y, 24'($urandom()));
      end else begin
        x = (ow > 0 && $urandom_range(9) != 0) ? $urandom_range(ow - 1) : $urandom_range(1023);
        y = (oh > 0 && $urandom_range(9) != 0) ? $urandom_range(oh - 1) : $urandom_range(1023);
        read_pixel(x, y);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frame();
    test_each_mode();
    src_idle_pct = 0;  sink_stall_pct = 0;  test_random_traffic(175);
    src_idle_pct = 52; sink_stall_pct = 0;  test_random_traffic(175);
    src_idle_pct = 0;  sink_stall_pct = 52; test_random_traffic(175);
    src_idle_pct = 24; sink_stall_pct = 24; test_random_traffic(175);
    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
sv/igt_pkg.sv
sv/igt_ram.sv
sv/igt_front.sv
sv/igt_queue.sv
sv/igt_back.sv
sv/image_geometric_transform.sv
sim/tb_image_geometric_transform.sv
